// ===== sv/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 transcoder: shared constants, the sequence
// state and step result structs, and the lead byte decode function.
// No dependencies.
package u8u16_pkg;

    localparam logic [15:0] ReplUnit    = 16'hFFFD;
    localparam logic [15:0] HiSurrBase  = 16'hD800;
    localparam logic [15:0] LoSurrBase  = 16'hDC00;
    localparam logic [20:0] SuppBase    = 21'h010000;
    localparam logic [20:0] MaxCodePt   = 21'h10FFFF;
    localparam logic [20:0] MaxBmp      = 21'h00FFFF;
    localparam logic [20:0] MaxTwoByte  = 21'h0007FF;
    localparam logic [20:0] MaxOneByte  = 21'h00007F;

    localparam logic [2:0] LenNone  = 3'd0;
    localparam logic [2:0] LenTwo   = 3'd2;
    localparam logic [2:0] LenThree = 3'd3;
    localparam logic [2:0] LenFour  = 3'd4;

    typedef struct packed {
        logic [2:0]  exp_len;
        logic [1:0]  seen;
        logic [20:0] acc;
    } t_seq_state;

    typedef struct packed {
        logic [1:0]  cnt;
        logic [15:0] unit0;
        logic        last0;
        logic [15:0] unit1;
        logic        last1;
        t_seq_state  nxt;
    } t_step_res;

    typedef struct packed {
        logic        is_unit;
        logic [15:0] unit;
        t_seq_state  seq;
    } t_lead;

    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead r;
        r.is_unit = 1'b0;
        r.unit    = ReplUnit;
        r.seq     = '0;
        if (b[7] == 1'b0) begin
            r.is_unit = 1'b1;
            r.unit    = {8'h00, b};
        end else if (b[7:5] == 3'b110) begin
            r.seq = '{exp_len: LenTwo, seen: 2'd1, acc: {16'h0000, b[4:0]}};
        end else if (b[7:4] == 4'b1110) begin
            r.seq = '{exp_len: LenThree, seen: 2'd1, acc: {17'h00000, b[3:0]}};
        end else if (b[7:3] == 5'b11110) begin
            r.seq = '{exp_len: LenFour, seen: 2'd1, acc: {18'h00000, b[2:0]}};
        end else begin
            r.is_unit = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== sv/u8u16_step.sv =====
// Combinational step of the transcoder: one byte plus the pending sequence
// state in, up to two UTF-16 units and the next state out. Uses u8u16_pkg.
module u8u16_step
    import u8u16_pkg::*;
(
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_string,
    input  t_seq_state i_state,
    output t_step_res  o_res
);

    t_lead       lead;
    logic [20:0] acc_ext;
    logic [1:0]  seen_inc;
    logic        done;
    logic        bad;
    logic [20:0] cp_off;

    assign lead     = lead_decode(i_data_byte);
    assign acc_ext  = {i_state.acc[14:0], i_data_byte[5:0]};
    assign seen_inc = i_state.seen + 2'd1;
    assign done     = ({1'b0, seen_inc} >= i_state.exp_len) || (seen_inc == 2'd0);
    assign cp_off   = acc_ext - SuppBase;

    always_comb begin
        case (i_state.exp_len)
            LenTwo:   bad = (acc_ext <= MaxOneByte);
            LenThree: bad = (acc_ext <= MaxTwoByte);
            default:  bad = (acc_ext <= MaxBmp) || (acc_ext > MaxCodePt);
        endcase
    end

    always_comb begin
        logic [1:0]  cnt;
        logic [15:0] u0;
        logic [15:0] u1;
        t_seq_state  nxt;
        cnt = 2'd0;
        u0  = ReplUnit;
        u1  = ReplUnit;
        nxt = i_state;

        if (i_state.exp_len != LenNone && i_data_byte[7:6] == 2'b10) begin
            nxt.acc  = acc_ext;
            nxt.seen = seen_inc;
            if (done) begin
                nxt = '0;
                if (bad) begin
                    cnt = 2'd1;
                end else if (acc_ext < SuppBase) begin
                    u0  = acc_ext[15:0];
                    cnt = 2'd1;
                end else begin
                    u0  = HiSurrBase + {6'd0, cp_off[19:10]};
                    u1  = LoSurrBase + {6'd0, cp_off[9:0]};
                    cnt = 2'd2;
                end
            end
        end else begin
            // broken sequence: replace, then take the byte as a lead
            if (i_state.exp_len != LenNone) begin
                cnt = 2'd1;
            end
            nxt = lead.seq;
            if (lead.is_unit) begin
                if (cnt == 2'd0) begin
                    u0 = lead.unit;
                end else begin
                    u1 = lead.unit;
                end
                cnt = cnt + 2'd1;
            end
        end

        // replace an unfinished sequence at the end of the string
        if (i_end_of_string && nxt.exp_len != LenNone) begin
            if (cnt == 2'd0) begin
                u0 = ReplUnit;
            end else begin
                u1 = ReplUnit;
            end
            cnt = cnt + 2'd1;
            nxt = '0;
        end

        o_res.cnt   = cnt;
        o_res.unit0 = u0;
        o_res.unit1 = u1;
        o_res.last0 = i_end_of_string && (cnt == 2'd1);
        o_res.last1 = i_end_of_string && (cnt == 2'd2);
        o_res.nxt   = nxt;
    end

endmodule

// ===== sv/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder top level: input register, step logic and a
// two-entry result buffer. Depends on u8u16_pkg and u8u16_step.
// An accepted byte passes the input register and the step logic into the
// result buffer, which drives o_valid. Rate: one byte per cycle while i_stall
// is low; after a byte that yields two units the buffer must drain first.
// Reset (synchronous, active low) clears the pending sequence and all valids.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_unit,
    output logic        o_last_unit
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eos;
    t_seq_state  r_state;
    logic [1:0]  r_cnt;
    logic [15:0] r_unit0;
    logic [15:0] r_unit1;
    logic        r_last0;
    logic        r_last1;

    t_step_res   res;
    logic        take;
    logic        proc;

    u8u16_step u_step (
        .i_data_byte     (r_in_byte),
        .i_end_of_string (r_in_eos),
        .i_state         (r_state),
        .o_res           (res)
    );

    assign take    = (r_cnt != 2'd0) && !i_stall;
    // process only when the buffer will be empty after this edge
    assign proc    = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && take));
    assign o_stall = r_in_valid && !proc;

    assign o_valid     = (r_cnt != 2'd0);
    assign o_code_unit = r_unit0;
    assign o_last_unit = r_last0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_cnt      <= 2'd0;
        end else begin
            if (!r_in_valid || proc) begin
                r_in_valid <= i_valid;
            end
            if (proc) begin
                r_state <= res.nxt;
                r_cnt   <= res.cnt;
            end else if (take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_in_valid || proc) && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_string;
        end
        if (proc) begin
            r_unit0 <= res.unit0;
            r_last0 <= res.last0;
            r_unit1 <= res.unit1;
            r_last1 <= res.last1;
        end else if (take) begin
            // advance the second unit to the head
            r_unit0 <= r_unit1;
            r_last0 <= r_last1;
        end
    end

endmodule
